// File: hw/rtl/msie_pkg.sv
`default_nettype none
package msie_pkg;

  localparam logic [31:0] HaltWord = 32'hfeedfeed;
  localparam logic [31:0] ImmLoMask = 32'h0000FFFF;
  localparam logic [31:0] ImmHiMask = 32'hFFFF0000;
  localparam logic [31:0] ImmSign = 32'h00008000;
  localparam logic [31:0] JumpRegionMask = ~32'h0FFFFFFF;

  localparam logic [5:0] OpSpecial = 6'h00;
  localparam logic [5:0] OpJ = 6'h02;
  localparam logic [5:0] OpJal = 6'h03;
  localparam logic [5:0] OpBeq = 6'h04;
  localparam logic [5:0] OpBne = 6'h05;
  localparam logic [5:0] OpBlez = 6'h06;
  localparam logic [5:0] OpBgtz = 6'h07;
  localparam logic [5:0] OpAddi = 6'h08;
  localparam logic [5:0] OpAddiu = 6'h09;
  localparam logic [5:0] OpSlti = 6'h0a;
  localparam logic [5:0] OpSltiu = 6'h0b;
  localparam logic [5:0] OpAndi = 6'h0c;
  localparam logic [5:0] OpOri = 6'h0d;
  localparam logic [5:0] OpLui = 6'h0f;
  localparam logic [5:0] OpLw = 6'h23;
  localparam logic [5:0] OpLbu = 6'h24;
  localparam logic [5:0] OpLhu = 6'h25;
  localparam logic [5:0] OpSb = 6'h28;
  localparam logic [5:0] OpSh = 6'h29;
  localparam logic [5:0] OpSw = 6'h2b;

  localparam logic [5:0] FnSll = 6'h00;
  localparam logic [5:0] FnSrl = 6'h02;
  localparam logic [5:0] FnJr = 6'h08;
  localparam logic [5:0] FnAdd = 6'h20;
  localparam logic [5:0] FnAddu = 6'h21;
  localparam logic [5:0] FnSub = 6'h22;
  localparam logic [5:0] FnSubu = 6'h23;
  localparam logic [5:0] FnAnd = 6'h24;
  localparam logic [5:0] FnOr = 6'h25;
  localparam logic [5:0] FnNor = 6'h27;
  localparam logic [5:0] FnSlt = 6'h2a;
  localparam logic [5:0] FnSltu = 6'h2b;

  localparam logic [4:0] LinkReg = 5'd31;
  localparam logic [4:0] ZeroReg = 5'd0;

  typedef enum logic [1:0] {
    StRun  = 2'd0,
    StHalt = 2'd1,
    StOvf  = 2'd2,
    StIll  = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    SzByte = 2'd0,
    SzHalf = 2'd1,
    SzWord = 2'd2
  } mem_size_e;

  typedef enum logic [1:0] {
    FwdNone = 2'd0,
    FwdVal  = 2'd1,
    FwdLoad = 2'd2
  } fwd_sel_e;

  typedef struct packed {
    logic [31:0] next_pc;
    status_e     status;
    logic        fault;
    logic        reg_wr;
    logic [4:0]  reg_idx;
    logic [31:0] reg_val;
    logic        ld;
    mem_size_e   ld_size;
    logic [31:0] ea;
    logic        mem_wr;
    logic [31:0] mem_addr;
    logic [31:0] mem_val;
    mem_size_e   mem_size;
  } exec_res_t;

  // big-endian lane select: byte offset 0 sits in bits 31:24
  function automatic logic [31:0] load_extract(input logic [31:0] word,
                                               input logic [1:0] offs,
                                               input mem_size_e size);
    logic [31:0] res;
    res = word;
    case (size)
      SzByte: begin
        case (offs)
          2'd0: res = {24'd0, word[31:24]};
          2'd1: res = {24'd0, word[23:16]};
          2'd2: res = {24'd0, word[15:8]};
          default: res = {24'd0, word[7:0]};
        endcase
      end
      SzHalf: res = offs[1] ? {16'd0, word[15:0]} : {16'd0, word[31:16]};
      default: res = word;
    endcase
    return res;
  endfunction

endpackage
`default_nettype wire

// File: hw/rtl/msie_ram.sv
`default_nettype none
module msie_ram #(
  parameter int Width = 32,
  parameter int Depth = 32
) (
  input  wire                       clk_i,
  input  wire  [Width/8-1:0]        we_i,
  input  wire  [$clog2(Depth)-1:0]  waddr_i,
  input  wire  [Width-1:0]          wdata_i,
  input  wire                       re_i,
  input  wire  [$clog2(Depth)-1:0]  raddr_i,
  output logic [Width-1:0]          rdata_o
);

  localparam int NumBytes = Width / 8;

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < NumBytes; i++) begin
      if (we_i[i]) begin
        mem_q[waddr_i][8*i +: 8] <= wdata_i[8*i +: 8];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/msie_exec.sv
`default_nettype none
module msie_exec (
  input  wire                  operation_i,
  input  wire  [31:0]          instr_i,
  input  wire  [31:0]          pc_i,
  input  msie_pkg::status_e    stop_i,
  input  wire  [31:0]          a_i,
  input  wire  [31:0]          b_i,
  output msie_pkg::exec_res_t  res_o
);
  import msie_pkg::*;

  logic [5:0]  op, fn;
  logic [4:0]  rt, rd, sham;
  logic [31:0] zimm, simm, pc4, tgt, jtgt;
  logic [31:0] add_ab, sub_ab, add_ai;
  logic        ovf_add, ovf_sub, ovf_addi;

  assign op     = instr_i[31:26];
  assign rt     = instr_i[20:16];
  assign rd     = instr_i[15:11];
  assign sham   = instr_i[10:6];
  assign fn     = instr_i[5:0];
  assign zimm   = instr_i & ImmLoMask;
  assign simm   = (zimm ^ ImmSign) - ImmSign;
  assign pc4    = pc_i + 32'd4;
  assign tgt    = pc4 + {simm[29:0], 2'b00};
  assign jtgt   = (pc4 & JumpRegionMask) | {4'd0, instr_i[25:0], 2'b00};
  assign add_ab = a_i + b_i;
  assign sub_ab = a_i - b_i;
  assign add_ai = a_i + simm;
  assign ovf_add  = ~(a_i[31] ^ b_i[31]) & (a_i[31] ^ add_ab[31]);
  assign ovf_sub  = (a_i[31] ^ b_i[31]) & (a_i[31] ^ sub_ab[31]);
  assign ovf_addi = ~(a_i[31] ^ simm[31]) & (a_i[31] ^ add_ai[31]);

  always_comb begin
    exec_res_t r;
    status_e   flt;
    r         = '0;
    flt       = StRun;
    r.next_pc = pc4;
    r.status  = StRun;
    r.ea      = add_ai;
    if (operation_i || (stop_i != StRun)) begin
      r.next_pc = pc_i;
      r.status  = stop_i;
    end else begin
      if (instr_i == HaltWord) begin
        flt = StHalt;
      end else if (instr_i == 32'd0) begin
        r.reg_wr = 1'b0;
      end else if (op == OpSpecial) begin
        r.reg_wr  = 1'b1;
        r.reg_idx = rd;
        case (fn)
          FnAdd: begin
            r.reg_val = add_ab;
            if (ovf_add) flt = StOvf;
          end
          FnAddu: r.reg_val = add_ab;
          FnSub: begin
            r.reg_val = sub_ab;
            if (ovf_sub) flt = StOvf;
          end
          FnSubu: r.reg_val = sub_ab;
          FnAnd:  r.reg_val = a_i & b_i;
          FnOr:   r.reg_val = a_i | b_i;
          FnNor:  r.reg_val = ~(a_i | b_i);
          FnSlt:  r.reg_val = {31'd0, $signed(a_i) < $signed(b_i)};
          FnSltu: r.reg_val = {31'd0, a_i < b_i};
          FnSll:  r.reg_val = b_i << sham;
          FnSrl:  r.reg_val = b_i >> sham;
          FnJr: begin
            r.reg_wr  = 1'b0;
            r.next_pc = a_i;
          end
          default: flt = StIll;
        endcase
      end else if (op == OpJ || op == OpJal) begin
        r.next_pc = jtgt;
        if (op == OpJal) begin
          r.reg_wr  = 1'b1;
          r.reg_idx = LinkReg;
          r.reg_val = pc_i + 32'd8;
        end
      end else begin
        r.reg_wr  = 1'b1;
        r.reg_idx = rt;
        case (op)
          OpAddi: begin
            r.reg_val = add_ai;
            if (ovf_addi) flt = StOvf;
          end
          OpAddiu: r.reg_val = add_ai;
          OpAndi:  r.reg_val = a_i & zimm;
          OpOri:   r.reg_val = a_i | zimm;
          OpSlti:  r.reg_val = {31'd0, $signed(a_i) < $signed(simm)};
          OpSltiu: r.reg_val = {31'd0, a_i < simm};
          OpLui:   r.reg_val = (zimm << 16) & ImmHiMask;
          OpLw: begin
            r.ld      = 1'b1;
            r.ld_size = SzWord;
          end
          OpLbu: begin
            r.ld      = 1'b1;
            r.ld_size = SzByte;
          end
          OpLhu: begin
            r.ld      = 1'b1;
            r.ld_size = SzHalf;
          end
          OpSw: begin
            r.reg_wr   = 1'b0;
            r.mem_wr   = 1'b1;
            r.mem_size = SzWord;
            r.mem_val  = b_i;
          end
          OpSb: begin
            r.reg_wr   = 1'b0;
            r.mem_wr   = 1'b1;
            r.mem_size = SzByte;
            r.mem_val  = {24'd0, b_i[7:0]};
          end
          OpSh: begin
            r.reg_wr   = 1'b0;
            r.mem_wr   = 1'b1;
            r.mem_size = SzHalf;
            r.mem_val  = {16'd0, b_i[15:0]};
          end
          OpBeq: begin
            r.reg_wr = 1'b0;
            if (a_i == b_i) r.next_pc = tgt;
          end
          OpBne: begin
            r.reg_wr = 1'b0;
            if (a_i != b_i) r.next_pc = tgt;
          end
          OpBgtz: begin
            r.reg_wr = 1'b0;
            if (a_i != 32'd0 && !a_i[31]) r.next_pc = tgt;
          end
          OpBlez: begin
            r.reg_wr = 1'b0;
            if (a_i == 32'd0 || a_i[31]) r.next_pc = tgt;
          end
          default: begin
            r.reg_wr = 1'b0;
            flt      = StIll;
          end
        endcase
      end

      if (flt != StRun) begin
        r         = '0;
        r.next_pc = pc_i;
        r.status  = flt;
        r.fault   = 1'b1;
      end else begin
        if (r.mem_wr) r.mem_addr = add_ai;
        // drop writes to the zero register
        if (!r.reg_wr || r.reg_idx == ZeroReg) begin
          r.reg_wr  = 1'b0;
          r.reg_idx = ZeroReg;
          r.reg_val = 32'd0;
          r.ld      = 1'b0;
        end
      end
    end
    res_o = r;
  end

endmodule
`default_nettype wire

// File: hw/rtl/mips_subset_instruction_executor.sv
// A transaction is registered in the execute stage and its result in the result stage.
// One instruction per cycle while the output is not stalled; after a load the next
// instruction waits while the load data is written to the register file.
// Reset clears pc, stop status and register-file valid bits (registers read 0);
// data memory is not cleared and holds garbage until preloaded or stored.
`default_nettype none
module mips_subset_instruction_executor #(
  parameter int MEM_WORDS = 4096
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         in_valid_i,
  output logic        in_ready_o,
  input  wire         operation_i,
  input  wire  [31:0] instruction_i,
  input  wire  [11:0] preload_address_i,
  input  wire  [31:0] preload_data_i,
  output logic        out_valid_o,
  input  wire         out_ready_i,
  output logic [31:0] next_pc_o,
  output logic [1:0]  run_status_o,
  output logic        reg_written_o,
  output logic [4:0]  reg_index_o,
  output logic [31:0] reg_value_o,
  output logic        mem_written_o,
  output logic [31:0] mem_address_o,
  output logic [31:0] mem_value_o,
  output logic [1:0]  mem_size_o
);
  import msie_pkg::*;

  localparam int AddrW = $clog2(MEM_WORDS);

  // execute stage
  logic        s1_valid_q;
  logic        operation_q;
  logic [31:0] instr_q;
  logic [11:0] pl_addr_q;
  logic [31:0] pl_data_q;
  fwd_sel_e    fwd_a_q, fwd_b_q, fwd_a_d, fwd_b_d;
  logic [31:0] fval_a_q, fval_b_q, fval_a_d, fval_b_d;
  logic        vld_a_q, vld_b_q;

  // architectural state
  logic [31:0] pc_q;
  status_e     stop_q;
  logic [31:0] rf_vld_q;

  // result stage
  logic        out_valid_q;
  logic [31:0] next_pc_q;
  status_e     status_q;
  logic        reg_wr_q;
  logic [4:0]  reg_idx_q;
  logic [31:0] reg_val_q;
  logic        mem_wr_q;
  logic [31:0] mem_addr_q;
  logic [31:0] mem_val_q;
  mem_size_e   mem_size_q;
  logic        ld_q;
  logic [1:0]  ld_offs_q;
  mem_size_e   ld_size_q;
  logic        ld_pend_q;

  logic        s1_adv, in_acc;
  logic [4:0]  rs_in, rt_in;
  logic [31:0] rf_a, rf_b, opa, opb, ld_val, dm_rdata;
  exec_res_t   res;

  logic        rf_we;
  logic [4:0]  rf_widx;
  logic [31:0] rf_wdata;

  logic [3:0]       dm_be, st_be;
  logic [31:0]      dm_wdata, st_data, pl_ext;
  logic [AddrW-1:0] dm_waddr, dm_raddr;
  logic             dm_re;

  assign s1_adv     = s1_valid_q && (!out_valid_q || out_ready_i) && !ld_pend_q;
  assign in_ready_o = !s1_valid_q || s1_adv;
  assign in_acc     = in_valid_i && in_ready_o;
  assign rs_in      = instruction_i[25:21];
  assign rt_in      = instruction_i[20:16];

  assign ld_val = load_extract(dm_rdata, ld_offs_q, ld_size_q);

  always_comb begin
    case (fwd_a_q)
      FwdVal:  opa = fval_a_q;
      FwdLoad: opa = ld_val;
      default: opa = vld_a_q ? rf_a : 32'd0;
    endcase
    case (fwd_b_q)
      FwdVal:  opb = fval_b_q;
      FwdLoad: opb = ld_val;
      default: opb = vld_b_q ? rf_b : 32'd0;
    endcase
  end

  msie_exec u_exec (
    .operation_i (operation_q),
    .instr_i     (instr_q),
    .pc_i        (pc_q),
    .stop_i      (stop_q),
    .a_i         (opa),
    .b_i         (opb),
    .res_o       (res)
  );

  // capture whatever is written to the register file at the accepting edge
  always_comb begin
    fwd_a_d  = FwdNone;
    fwd_b_d  = FwdNone;
    fval_a_d = res.reg_val;
    fval_b_d = res.reg_val;
    if (s1_adv && res.reg_wr && res.reg_idx == rs_in) begin
      fwd_a_d = res.ld ? FwdLoad : FwdVal;
    end else if (ld_pend_q && reg_idx_q == rs_in) begin
      fwd_a_d  = FwdVal;
      fval_a_d = ld_val;
    end
    if (s1_adv && res.reg_wr && res.reg_idx == rt_in) begin
      fwd_b_d = res.ld ? FwdLoad : FwdVal;
    end else if (ld_pend_q && reg_idx_q == rt_in) begin
      fwd_b_d  = FwdVal;
      fval_b_d = ld_val;
    end
  end

  // register file: two copies give two read ports
  assign rf_we    = ld_pend_q || (s1_adv && res.reg_wr && !res.ld);
  assign rf_widx  = ld_pend_q ? reg_idx_q : res.reg_idx;
  assign rf_wdata = ld_pend_q ? ld_val : res.reg_val;

  msie_ram #(.Width(32), .Depth(32)) u_rf_a (
    .clk_i   (clk_i),
    .we_i    ({4{rf_we}}),
    .waddr_i (rf_widx),
    .wdata_i (rf_wdata),
    .re_i    (in_acc),
    .raddr_i (rs_in),
    .rdata_o (rf_a)
  );

  msie_ram #(.Width(32), .Depth(32)) u_rf_b (
    .clk_i   (clk_i),
    .we_i    ({4{rf_we}}),
    .waddr_i (rf_widx),
    .wdata_i (rf_wdata),
    .re_i    (in_acc),
    .raddr_i (rt_in),
    .rdata_o (rf_b)
  );

  // data memory lanes, big-endian
  always_comb begin
    case (res.mem_size)
      SzByte: begin
        st_data = {4{res.mem_val[7:0]}};
        case (res.ea[1:0])
          2'd0: st_be = 4'b1000;
          2'd1: st_be = 4'b0100;
          2'd2: st_be = 4'b0010;
          default: st_be = 4'b0001;
        endcase
      end
      SzHalf: begin
        st_data = {2{res.mem_val[15:0]}};
        st_be   = res.ea[1] ? 4'b0011 : 4'b1100;
      end
      default: begin
        st_data = res.mem_val;
        st_be   = 4'b1111;
      end
    endcase
  end

  assign pl_ext   = 32'(pl_addr_q);
  assign dm_be    = !s1_adv ? 4'b0000 :
                    operation_q ? 4'b1111 :
                    res.mem_wr ? st_be : 4'b0000;
  assign dm_wdata = operation_q ? pl_data_q : st_data;
  assign dm_waddr = operation_q ? pl_ext[AddrW-1:0] : res.ea[AddrW+1:2];
  assign dm_raddr = res.ea[AddrW+1:2];
  assign dm_re    = s1_adv && res.ld;

  msie_ram #(.Width(32), .Depth(MEM_WORDS)) u_dmem (
    .clk_i   (clk_i),
    .we_i    (dm_be),
    .waddr_i (dm_waddr),
    .wdata_i (dm_wdata),
    .re_i    (dm_re),
    .raddr_i (dm_raddr),
    .rdata_o (dm_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      ld_pend_q   <= 1'b0;
      pc_q        <= 32'd0;
      stop_q      <= StRun;
      rf_vld_q    <= '0;
      fwd_a_q     <= FwdNone;
      fwd_b_q     <= FwdNone;
    end else begin
      if (in_acc) begin
        s1_valid_q <= 1'b1;
        fwd_a_q    <= fwd_a_d;
        fwd_b_q    <= fwd_b_d;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      ld_pend_q <= s1_adv && res.ld;
      if (s1_adv) begin
        pc_q <= res.next_pc;
        if (res.fault) stop_q <= res.status;
      end
      if (rf_we) rf_vld_q[rf_widx] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      operation_q <= operation_i;
      instr_q     <= instruction_i;
      pl_addr_q   <= preload_address_i;
      pl_data_q   <= preload_data_i;
      fval_a_q    <= fval_a_d;
      fval_b_q    <= fval_b_d;
      vld_a_q     <= rf_vld_q[rs_in];
      vld_b_q     <= rf_vld_q[rt_in];
    end
    if (s1_adv) begin
      next_pc_q  <= res.next_pc;
      status_q   <= res.status;
      reg_wr_q   <= res.reg_wr;
      reg_idx_q  <= res.reg_idx;
      reg_val_q  <= res.reg_val;
      mem_wr_q   <= res.mem_wr;
      mem_addr_q <= res.mem_addr;
      mem_val_q  <= res.mem_val;
      mem_size_q <= res.mem_size;
      ld_q       <= res.ld;
      ld_offs_q  <= res.ea[1:0];
      ld_size_q  <= res.ld_size;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign next_pc_o     = next_pc_q;
  assign run_status_o  = status_q;
  assign reg_written_o = reg_wr_q;
  assign reg_index_o   = reg_idx_q;
  assign reg_value_o   = ld_q ? ld_val : reg_val_q;
  assign mem_written_o = mem_wr_q;
  assign mem_address_o = mem_addr_q;
  assign mem_value_o   = mem_val_q;
  assign mem_size_o    = mem_size_q;

`ifndef SYNTH
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rf_we |-> rf_widx != ZeroReg)
    else $error("register zero written");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ld_pend_q |-> !s1_adv)
    else $error("instruction advanced during load writeback");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (stop_q != StRun) |=> pc_q == $past(pc_q))
    else $error("pc moved while stopped");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ld_pend_q |-> out_valid_q || $past(out_ready_i))
    else $error("load writeback without a load result");
`endif

endmodule
`default_nettype wire

// File: dv/mips_subset_instruction_executor_test.sv
`timescale 1ns / 100ps
`default_nettype none
module mips_subset_instruction_executor_test;
  import msie_pkg::*;

  typedef struct packed {
    logic        preload;
    logic [31:0] instr;
    logic [11:0] paddr;
    logic [31:0] pdata;
    logic        drain;
  } cpu_item_t;

  typedef struct packed {
    logic [31:0] npc;
    status_e     st;
    logic        rw;
    logic [4:0]  ri;
    logic [31:0] rv;
    logic        mw;
    logic [31:0] ma;
    logic [31:0] mv;
    logic [1:0]  ms;
  } cpu_effect_t;

  logic        clk, rst_n;
  logic        in_valid, in_ready, out_valid, out_ready;
  logic        operation;
  logic [31:0] instruction, preload_data;
  logic [11:0] preload_address;
  logic [31:0] next_pc, reg_value, mem_address, mem_value;
  logic [1:0]  run_status, mem_size;
  logic        reg_written, mem_written;
  logic [4:0]  reg_index;

  mips_subset_instruction_executor u_dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_ready_o(in_ready),
    .operation_i(operation), .instruction_i(instruction),
    .preload_address_i(preload_address), .preload_data_i(preload_data),
    .out_valid_o(out_valid), .out_ready_i(out_ready),
    .next_pc_o(next_pc), .run_status_o(run_status),
    .reg_written_o(reg_written), .reg_index_o(reg_index), .reg_value_o(reg_value),
    .mem_written_o(mem_written), .mem_address_o(mem_address),
    .mem_value_o(mem_value), .mem_size_o(mem_size)
  );

  // shadow architectural state
  logic [31:0] gpr [32];
  logic [31:0] arch_pc;
  status_e     arch_st;
  logic [31:0] dmem [4096];
  bit          word_valid [4096];
  int          valid_words[$];

  cpu_item_t   pending_q[$];
  cpu_effect_t effect_q[$];
  int n_items, n_acc, n_res, n_err;
  bit gen_done, in_fire;
  int in_gap, out_gap;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("mips_subset_instruction_executor test failed");
    $finish;
  end

  function automatic logic [31:0] rtype(logic [5:0] fn, int rs, int rt, int rd, int sh);
    return {OpSpecial, 5'(rs), 5'(rt), 5'(rd), 5'(sh), fn};
  endfunction

  function automatic logic [31:0] itype(logic [5:0] op, int rs, int rt, logic [15:0] imm);
    return {op, 5'(rs), 5'(rt), imm};
  endfunction

  function automatic logic [31:0] lane_read(logic [31:0] ea, logic [1:0] sz);
    logic [31:0] w;
    w = dmem[ea[13:2]];
    if (sz == SzByte) return (w >> ((3 - ea[1:0]) * 8)) & 32'hff;
    if (sz == SzHalf) return ea[1] ? {16'd0, w[15:0]} : {16'd0, w[31:16]};
    return w;
  endfunction

  // execute one transaction against the shadow state; commit only when asked
  function automatic status_e cpu_execute(cpu_item_t it, bit commit, output cpu_effect_t e);
    logic [31:0] ins, a, b, simm, zimm, ea, npc, wval, sval, r, tgt, w;
    logic [5:0]  op, fn;
    logic [4:0]  rs, rt, rd, sh, widx;
    logic [1:0]  ssz;
    bit          wr, st;
    status_e     fault;
    ins = it.instr;
    op = ins[31:26]; rs = ins[25:21]; rt = ins[20:16]; rd = ins[15:11];
    sh = ins[10:6]; fn = ins[5:0];
    zimm = {16'd0, ins[15:0]};
    simm = {{16{ins[15]}}, ins[15:0]};
    a = gpr[rs]; b = gpr[rt]; ea = a + simm;
    npc = arch_pc + 4; wr = 0; st = 0; widx = 0; wval = 0; sval = 0; ssz = SzByte;
    fault = StRun;
    e = '0;
    e.npc = arch_pc;
    e.st = arch_st;
    if (it.preload) begin
      if (commit) begin
        dmem[it.paddr] = it.pdata;
        if (!word_valid[it.paddr]) valid_words.push_back(it.paddr);
        word_valid[it.paddr] = 1;
      end
      return arch_st;
    end
    if (arch_st != StRun) return arch_st;
    if (ins == HaltWord) fault = StHalt;
    else if (ins == 32'd0) ;
    else if (op == OpSpecial) begin
      wr = 1; widx = rd;
      case (fn)
        FnAdd: begin
          r = a + b;
          if (a[31] == b[31] && r[31] != a[31]) fault = StOvf;
          wval = r;
        end
        FnAddu: wval = a + b;
        FnSub: begin
          r = a - b;
          if (a[31] != b[31] && r[31] != a[31]) fault = StOvf;
          wval = r;
        end
        FnSubu: wval = a - b;
        FnAnd: wval = a & b;
        FnOr: wval = a | b;
        FnNor: wval = ~(a | b);
        FnSlt: wval = ($signed(a) < $signed(b)) ? 1 : 0;
        FnSltu: wval = (a < b) ? 1 : 0;
        FnSll: wval = b << sh;
        FnSrl: wval = b >> sh;
        FnJr: begin wr = 0; npc = a; end
        default: fault = StIll;
      endcase
    end else if (op == OpJ || op == OpJal) begin
      npc = ((arch_pc + 4) & JumpRegionMask) | {4'd0, ins[25:0], 2'd0};
      if (op == OpJal) begin wr = 1; widx = LinkReg; wval = arch_pc + 8; end
    end else begin
      tgt = arch_pc + 4 + (simm << 2);
      wr = 1; widx = rt;
      case (op)
        OpAddi: begin
          r = a + simm;
          if (a[31] == simm[31] && r[31] != a[31]) fault = StOvf;
          wval = r;
        end
        OpAddiu: wval = a + simm;
        OpAndi: wval = a & zimm;
        OpOri: wval = a | zimm;
        OpSlti: wval = ($signed(a) < $signed(simm)) ? 1 : 0;
        OpSltiu: wval = (a < simm) ? 1 : 0;
        OpLui: wval = zimm << 16;
        OpLw: wval = lane_read(ea, SzWord);
        OpLbu: wval = lane_read(ea, SzByte);
        OpLhu: wval = lane_read(ea, SzHalf);
        OpSw: begin wr = 0; st = 1; ssz = SzWord; sval = b; end
        OpSb: begin wr = 0; st = 1; ssz = SzByte; sval = b & 32'hff; end
        OpSh: begin wr = 0; st = 1; ssz = SzHalf; sval = b & 32'hffff; end
        OpBeq: begin wr = 0; if (a == b) npc = tgt; end
        OpBne: begin wr = 0; if (a != b) npc = tgt; end
        OpBgtz: begin wr = 0; if ($signed(a) > 0) npc = tgt; end
        OpBlez: begin wr = 0; if ($signed(a) <= 0) npc = tgt; end
        default: begin wr = 0; fault = StIll; end
      endcase
    end
    if (fault != StRun) begin
      e.st = fault;
      if (commit) arch_st = fault;
      return fault;
    end
    if (wr && widx != ZeroReg) begin
      e.rw = 1; e.ri = widx; e.rv = wval;
      if (commit) gpr[widx] = wval;
    end
    if (st) begin
      e.mw = 1; e.ma = ea; e.mv = sval; e.ms = ssz;
      if (commit) begin
        w = dmem[ea[13:2]];
        if (ssz == SzWord) w = sval;
        else if (ssz == SzHalf) begin
          if (ea[1]) w[15:0] = sval[15:0]; else w[31:16] = sval[15:0];
        end else w[(3 - ea[1:0]) * 8 +: 8] = sval[7:0];
        dmem[ea[13:2]] = w;
        // partial stores leave the rest of an unwritten word undefined
        if (ssz == SzWord && !word_valid[ea[13:2]]) begin
          word_valid[ea[13:2]] = 1;
          valid_words.push_back(ea[13:2]);
        end
      end
    end
    e.npc = npc;
    e.st = StRun;
    if (commit) arch_pc = npc;
    return StRun;
  endfunction

  function automatic void queue_item(cpu_item_t it);
    cpu_effect_t e;
    void'(cpu_execute(it, 1, e));
    pending_q.push_back(it);
    effect_q.push_back(e);
    n_items++;
  endfunction

  function automatic cpu_item_t exec_item(logic [31:0] ins);
    cpu_item_t it;
    it = '0;
    it.instr = ins;
    it.paddr = 12'($urandom);
    it.pdata = $urandom;
    return it;
  endfunction

  function automatic cpu_item_t preload_item(logic [11:0] adr, logic [31:0] dat);
    cpu_item_t it;
    it = '0;
    it.preload = 1;
    it.instr = $urandom;
    it.paddr = adr;
    it.pdata = dat;
    return it;
  endfunction

  // load that only touches words already written
  function automatic logic [31:0] safe_load(logic [5:0] op);
    logic [31:0] tgt, diff;
    logic [11:0] widx;
    int rs;
    widx = 12'(valid_words[$urandom_range(0, valid_words.size() - 1)]);
    tgt = {18'd0, widx, 2'($urandom)};
    rs = $urandom_range(0, 31);
    diff = tgt + 32'($urandom_range(0, 3)) * 32'd16384 - gpr[rs];
    if ($signed(diff) >= -32768 && $signed(diff) <= 32767)
      return itype(op, rs, $urandom_range(0, 31), diff[15:0]);
    return itype(op, 0, $urandom_range(0, 31), tgt[15:0]);
  endfunction

  function automatic logic [31:0] rand_instr();
    logic [5:0] fns[12] = '{FnAdd, FnAddu, FnSub, FnSubu, FnAnd, FnOr, FnNor, FnSlt,
                            FnSltu, FnSll, FnSrl, FnJr};
    logic [5:0] iops[12] = '{OpAddi, OpAddiu, OpAndi, OpOri, OpSlti, OpSltiu, OpLui,
                             OpSw, OpSb, OpSh, OpBeq, OpBne};
    logic [5:0] bops[4] = '{OpBeq, OpBne, OpBgtz, OpBlez};
    logic [5:0] lops[3] = '{OpLw, OpLbu, OpLhu};
    int k;
    k = $urandom_range(0, 99);
    if (k < 35)
      return rtype(fns[$urandom_range(0, 11)], $urandom_range(0, 31),
                   $urandom_range(0, 31), $urandom_range(0, 31), $urandom_range(0, 31));
    if (k < 65) return {iops[$urandom_range(0, 11)], 26'($urandom)};
    if (k < 80) return safe_load(lops[$urandom_range(0, 2)]);
    if (k < 90) return {bops[$urandom_range(0, 3)], 26'($urandom)};
    if (k < 96) return {($urandom_range(0, 1) ? OpJal : OpJ), 26'($urandom)};
    return 32'd0;
  endfunction

  initial begin
    cpu_item_t   it;
    cpu_effect_t e;
    logic [31:0] ins;
    int          f;
    for (int i = 0; i < 32; i++) gpr[i] = '0;
    arch_pc = '0;
    arch_st = StRun;
    gen_done = 0;
    n_items = 0;
    for (int i = 0; i < 8; i++)
      queue_item(preload_item(12'(i), (i == 0) ? 32'h0 : (i == 1) ? 32'hffffffff : $urandom));
    queue_item(preload_item(12'hfff, 32'h8badf00d));
    queue_item(exec_item(itype(OpLui, 0, 1, 16'h8000)));
    queue_item(exec_item(itype(OpAddiu, 0, 2, 16'hffff)));
    queue_item(exec_item(itype(OpOri, 0, 3, 16'hffff)));
    queue_item(exec_item(itype(OpAddi, 0, 4, 16'h7fff)));
    queue_item(exec_item(itype(OpAndi, 2, 5, 16'h8001)));
    queue_item(exec_item(rtype(FnAdd, 3, 4, 6, 0)));
    queue_item(exec_item(rtype(FnSub, 1, 1, 7, 0)));
    queue_item(exec_item(rtype(FnSlt, 1, 2, 8, 0)));
    queue_item(exec_item(rtype(FnSltu, 1, 2, 9, 0)));
    queue_item(exec_item(rtype(FnNor, 0, 0, 0, 0)));        // write to r0 dropped
    queue_item(exec_item(rtype(FnSll, 0, 2, 10, 31)));
    queue_item(exec_item(rtype(FnSrl, 0, 2, 11, 31)));
    queue_item(exec_item(itype(OpSlti, 1, 12, 16'h8000)));
    queue_item(exec_item(itype(OpSltiu, 2, 13, 16'hffff)));
    queue_item(exec_item(itype(OpLw, 0, 14, 16'h0004)));
    queue_item(exec_item(rtype(FnAddu, 14, 14, 15, 0)));   // load then use
    queue_item(exec_item(itype(OpLbu, 0, 16, 16'h0007)));
    queue_item(exec_item(itype(OpLhu, 0, 17, 16'h3ffd)));  // misaligned, top word
    queue_item(exec_item(itype(OpSb, 0, 2, 16'h0009)));
    queue_item(exec_item(itype(OpSh, 0, 1, 16'h000b)));
    queue_item(exec_item(itype(OpSw, 2, 1, 16'h0001)));
    queue_item(exec_item(itype(OpBgtz, 1, 0, 16'h0004)));
    queue_item(exec_item(itype(OpBlez, 1, 0, 16'hfffe)));
    queue_item(exec_item({OpJal, 26'h3ffffff}));
    queue_item(exec_item(rtype(FnJr, 31, 0, 0, 0)));
    queue_item(exec_item(32'd0));
    for (int n = 0; n < 500; n++) begin
      if ($urandom_range(0, 9) == 0) begin
        it = preload_item(12'($urandom), $urandom);
      end else begin
        do begin
          it = exec_item(rand_instr());
        end while (cpu_execute(it, 0, e) != StRun);
      end
      if (n == 250) it.drain = 1;
      queue_item(it);
    end
    // the block stops for good after a fault, so exercise one kind at the end
    f = $urandom_range(0, 2);
    if (f == 0) ins = HaltWord;
    else if (f == 1) begin
      queue_item(exec_item(itype(OpLui, 0, 20, 16'h7fff)));
      queue_item(exec_item(itype(OpOri, 20, 20, 16'hffff)));
      ins = itype(OpAddi, 20, 21, 16'h0001);
    end else ins = $urandom_range(0, 1) ? {6'h3f, 26'($urandom)} : rtype(6'h3f, 1, 2, 3, 0);
    it = exec_item(ins);
    it.drain = 1;
    queue_item(it);
    for (int n = 0; n < 6; n++)
      queue_item((n == 3) ? preload_item(12'($urandom), $urandom) : exec_item($urandom));
    gen_done = 1;
  end

  function automatic int pick_gap();
    int k;
    k = $urandom_range(0, 99);
    if (k < 55) return 0;
    if (k < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 25);
  endfunction

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    out_ready = 1'b0;
    operation = 1'b0;
    instruction = '0;
    preload_address = '0;
    preload_data = '0;
    in_gap = 0;
    out_gap = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
  end

  // driver: advance to the next pending transaction once the current one is taken
  always @(negedge clk) begin
    if (rst_n && (!in_valid || in_fire)) begin
      if (in_gap > 0) begin
        in_valid <= 1'b0;
        in_gap <= in_gap - 1;
      end else if (pending_q.size() > 0 && !(pending_q[0].drain && n_acc != n_res)) begin
        operation <= pending_q[0].preload;
        instruction <= pending_q[0].instr;
        preload_address <= pending_q[0].paddr;
        preload_data <= pending_q[0].pdata;
        void'(pending_q.pop_front());
        in_valid <= 1'b1;
        // hold a back-to-back stretch in the middle of the run
        in_gap <= (pending_q.size() > 150 && pending_q.size() < 220) ? 0 : pick_gap();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (rst_n) begin
      if (out_gap > 0) begin
        out_ready <= 1'b0;
        out_gap <= out_gap - 1;
      end else begin
        out_ready <= 1'b1;
        out_gap <= pick_gap();
      end
    end
  end

  // monitor: compare each retired transaction with the oldest prediction
  always @(posedge clk) begin
    cpu_effect_t x;
    in_fire <= in_valid && in_ready;
    if (in_valid && in_ready) n_acc <= n_acc + 1;
    if (rst_n && out_valid && out_ready) begin
      n_res <= n_res + 1;
      if (effect_q.size() == 0) begin
        n_err++;
        if (n_err <= 10) $display("unexpected result: next_pc %h", next_pc);
      end else begin
        x = effect_q.pop_front();
        if (next_pc !== x.npc || run_status !== x.st || reg_written !== x.rw ||
            reg_index !== x.ri || reg_value !== x.rv || mem_written !== x.mw ||
            mem_address !== x.ma || mem_value !== x.mv || mem_size !== x.ms) begin
          n_err++;
          if (n_err <= 10) begin
            $display("mismatch: exp pc %h st %0d r %b/%0d/%h m %b/%h/%h/%0d",
                     x.npc, x.st, x.rw, x.ri, x.rv, x.mw, x.ma, x.mv, x.ms);
            $display("          got pc %h st %0d r %b/%0d/%h m %b/%h/%h/%0d",
                     next_pc, run_status, reg_written, reg_index, reg_value,
                     mem_written, mem_address, mem_value, mem_size);
          end
        end
      end
    end
  end

  initial begin
    n_acc = 0;
    n_res = 0;
    n_err = 0;
    in_fire = 0;
    wait (gen_done);
    while (pending_q.size() != 0 || in_valid || n_res < n_items) @(posedge clk);
    repeat (10) @(posedge clk);
    if (effect_q.size() != 0) n_err++;
    if (n_err == 0) $display("mips_subset_instruction_executor test passed");
    else $display("mips_subset_instruction_executor test failed");
    $finish;
  end

endmodule
`default_nettype wire
